FILE: hw/rtl/imse_pkg.sv
`default_nettype none

package imse_pkg;

  // Single-precision word and element counter widths
  localparam int unsigned FP_W  = 32;
  localparam int unsigned CNT_W = 25;

  // Exponent field code for infinity and NaN
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

  // Positive infinity and positive zero
  localparam logic [FP_W-1:0] FP_POS_INF  = 32'h7F80_0000;
  localparam logic [FP_W-1:0] FP_POS_ZERO = 32'h0000_0000;

  // Operations of the shared float unit
  typedef enum logic [1:0] {
    OP_SUB,
    OP_MUL,
    OP_ADD,
    OP_DIV
  } fpu_op_e;

  // Request from the sequencer to the float unit
  typedef struct packed {
    logic             start;
    fpu_op_e          op;
    logic [FP_W-1:0]  a;
    logic [FP_W-1:0]  b;
    logic [CNT_W-1:0] cnt;
  } fpu_req_t;

  // Response from the float unit
  typedef struct packed {
    logic            done;
    logic [FP_W-1:0] result;
  } fpu_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/image_mean_squared_error.sv
`default_nettype none

// Channel | Direction | Handshake                 | Beat fields
// in      | input     | in_valid_i / in_ready_o   | img_value_i, ref_value_i, last_element_i
// out     | output    | out_valid_o / out_ready_i | squared_error_o, mean_valid_o, mean_error_o
//
// One beat in gives one beat out. Each element runs through the shared float
// unit: subtract, square and accumulate in turn (accumulate is skipped when
// the square is not a normal number), each through its normalise loop (one bit
// a cycle, or sixteen at a time over long runs); the last element adds a
// restoring division for the mean.
// in_ready_o is high only while no element is in flight; the output register
// lets the next beat in while the previous result still waits.
// Reset clears the running sum to positive zero and the count to zero.
module image_mean_squared_error #(
  parameter int unsigned MAX_ELEMENTS = 16777216
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [31:0] img_value_i,
  input  wire logic [31:0] ref_value_i,
  input  wire logic        last_element_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] squared_error_o,
  output      logic        mean_valid_o,
  output      logic [31:0] mean_error_o
);

  localparam logic [imse_pkg::CNT_W-1:0] CNT_MAX = imse_pkg::CNT_W'(MAX_ELEMENTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALL = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                  state_q, state_d;
  imse_pkg::fpu_op_e           op_q, op_d;
  logic                        start_q, start_d;
  logic [31:0]                 a_q, a_d, b_q, b_d, diff_q, diff_d, sq_q, sq_d;
  logic [31:0]                 sum_q, sum_d, mean_q, mean_d;
  logic                        last_q, last_d;
  logic [imse_pkg::CNT_W-1:0]  count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 sq_out_q, sq_out_d, me_out_q, me_out_d;
  logic                        mv_out_q, mv_out_d;
  logic                        in_fire, out_load;
  imse_pkg::fpu_req_t          fpu_req;
  imse_pkg::fpu_rsp_t          fpu_rsp;

  // True for a normal number, false for zero, subnormal, infinity or NaN
  function automatic logic is_normal(input logic [31:0] v);
    is_normal = (v[30:23] != 8'd0) && (v[30:23] != imse_pkg::EXP_ALL_ONES);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Select operands for the shared unit
  always_comb begin
    fpu_req.start = start_q;
    fpu_req.op    = op_q;
    fpu_req.cnt   = count_q;
    case (op_q)
      imse_pkg::OP_SUB: begin
        fpu_req.a = a_q;
        fpu_req.b = b_q;
      end
      imse_pkg::OP_MUL: begin
        fpu_req.a = diff_q;
        fpu_req.b = diff_q;
      end
      imse_pkg::OP_ADD: begin
        fpu_req.a = sum_q;
        fpu_req.b = sq_q;
      end
      default: begin
        fpu_req.a = sum_q;
        fpu_req.b = imse_pkg::FP_POS_ZERO;
      end
    endcase
  end

  imse_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  // Sequence one element through subtract, square, accumulate and mean
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    start_d     = 1'b0;
    a_d         = a_q;
    b_d         = b_q;
    diff_d      = diff_q;
    sq_d        = sq_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    last_d      = last_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sq_out_d    = sq_out_q;
    mv_out_d    = mv_out_q;
    me_out_d    = me_out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          a_d     = is_normal(img_value_i) ? img_value_i : imse_pkg::FP_POS_ZERO;
          b_d     = is_normal(ref_value_i) ? ref_value_i : imse_pkg::FP_POS_ZERO;
          last_d  = last_element_i;
          op_d    = imse_pkg::OP_SUB;
          start_d = 1'b1;
          state_d = ST_CALL;
        end
      end
      ST_CALL: begin
        if (fpu_rsp.done) begin
          case (op_q)
            imse_pkg::OP_SUB: begin
              diff_d  = fpu_rsp.result;
              op_d    = imse_pkg::OP_MUL;
              start_d = 1'b1;
            end
            imse_pkg::OP_MUL: begin
              sq_d = fpu_rsp.result;
              if (count_q < CNT_MAX) begin
                count_d = count_q + imse_pkg::CNT_W'(1);
              end
              if (is_normal(fpu_rsp.result)) begin
                op_d    = imse_pkg::OP_ADD;
                start_d = 1'b1;
              end else if (last_q) begin
                op_d    = imse_pkg::OP_DIV;
                start_d = 1'b1;
              end else begin
                state_d = ST_OUT;
              end
            end
            imse_pkg::OP_ADD: begin
              sum_d = fpu_rsp.result;
              if (last_q) begin
                op_d    = imse_pkg::OP_DIV;
                start_d = 1'b1;
              end else begin
                state_d = ST_OUT;
              end
            end
            default: begin
              mean_d  = fpu_rsp.result;
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          sq_out_d    = sq_q;
          mv_out_d    = last_q;
          me_out_d    = last_q ? mean_q : imse_pkg::FP_POS_ZERO;
          if (last_q) begin
            sum_d   = imse_pkg::FP_POS_ZERO;
            count_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= imse_pkg::OP_SUB;
      start_q     <= 1'b0;
      sum_q       <= imse_pkg::FP_POS_ZERO;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      start_q     <= start_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold operands and the result beat
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    diff_q   <= diff_d;
    sq_q     <= sq_d;
    mean_q   <= mean_d;
    last_q   <= last_d;
    sq_out_q <= sq_out_d;
    mv_out_q <= mv_out_d;
    me_out_q <= me_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign squared_error_o = sq_out_q;
  assign mean_valid_o    = mv_out_q;
  assign mean_error_o    = me_out_q;

  // The float unit only answers a call that is in flight
  a_done_in_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_rsp.done |-> (state_q == ST_CALL))
    else $error("float unit answered outside a call");

  // A beat without the mean carries a zero mean
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mean_valid_o) |-> (mean_error_o == 32'd0))
    else $error("mean given on a beat that is not the last");

  // The final beat clears the accumulator
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> ((count_q == '0) && (sum_q == imse_pkg::FP_POS_ZERO)))
    else $error("state not cleared after the last element");

  // The count never passes its ceiling
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("element count beyond its ceiling");

endmodule

`default_nettype wire

FILE: hw/rtl/imse_fpu.sv
`default_nettype none

// Shared single-precision unit: magnitude difference, add, multiply and
// divide by an integer count, all through one normalise and round loop.
// Results here are never negative, so the sign bit is always clear.
module imse_fpu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire imse_pkg::fpu_req_t req_i,
  output imse_pkg::fpu_rsp_t     rsp_o
);

  localparam int unsigned MW = 52;          // working significand width
  localparam int unsigned EW = 11;          // working exponent width
  localparam logic [5:0] DIV_LAST = 6'd51;  // MW quotient steps

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_NORM = 2'd2;

  logic [1:0]                    phase_q, phase_d;
  logic [MW-1:0]                 nm_q, nm_d;
  logic signed [EW-1:0]          ne_q, ne_d;
  logic                          stk_q, stk_d;
  logic [imse_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [imse_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [5:0]                    step_q, step_d;
  logic [imse_pkg::FP_W-1:0]     res_q, res_d;
  logic                          done_q, done_d;

  // Operand unpacking and alignment
  logic                          swap;
  logic [imse_pkg::FP_W-1:0]     x_op, y_op;
  logic [23:0]                   x_sig, y_sig, a_sig, b_sig;
  logic [7:0]                    a_exp, b_exp, a_eexp, b_eexp, sh_amt;
  logic [MW-1:0]                 xm, ym, ys;
  logic                          al_stk;
  logic [MW:0]                   sub_ext;
  logic [MW-1:0]                 add_sum;
  logic [47:0]                   prod;
  logic signed [EW-1:0]          mul_exp;
  logic                          special;

  // Division step
  logic [imse_pkg::CNT_W:0]      rem_ext;
  logic                          div_ge;

  // Rounding
  logic [7:0]                    exf;
  logic                          rnd_up;
  logic [imse_pkg::FP_W-1:0]     packed_rnd;

  assign a_exp  = req_i.a[30:23];
  assign b_exp  = req_i.b[30:23];
  assign a_eexp = (a_exp == 8'd0) ? 8'd1 : a_exp;
  assign b_eexp = (b_exp == 8'd0) ? 8'd1 : b_exp;
  assign a_sig  = {|a_exp, req_i.a[22:0]};
  assign b_sig  = {|b_exp, req_i.b[22:0]};

  // Order operands by magnitude for the adder path
  assign swap   = req_i.b[30:0] > req_i.a[30:0];
  assign x_op   = swap ? req_i.b : req_i.a;
  assign y_op   = swap ? req_i.a : req_i.b;
  assign x_sig  = {|x_op[30:23], x_op[22:0]};
  assign y_sig  = {|y_op[30:23], y_op[22:0]};
  assign sh_amt = x_op[30:23] - y_op[30:23];
  assign xm     = {1'b0, x_sig, 27'd0};
  assign ym     = {1'b0, y_sig, 27'd0};

  // Align the smaller operand, keeping a sticky bit of what falls off
  always_comb begin
    if (sh_amt >= 8'(MW)) begin
      ys     = '0;
      al_stk = |y_sig;
    end else begin
      ys     = ym >> sh_amt;
      al_stk = |(ym & ~({MW{1'b1}} << sh_amt));
    end
  end

  assign sub_ext = {xm, 1'b0} - {ys, al_stk};
  assign add_sum = xm + ys;
  assign prod    = a_sig * b_sig;
  assign mul_exp = $signed({3'b000, a_eexp}) + $signed({3'b000, b_eexp}) - 11'sd127;

  assign special = ((req_i.op == imse_pkg::OP_ADD) && (x_op[30:23] == imse_pkg::EXP_ALL_ONES))
                || (((req_i.op == imse_pkg::OP_MUL) || (req_i.op == imse_pkg::OP_DIV))
                    && (a_exp == imse_pkg::EXP_ALL_ONES));

  // One restoring division step
  assign rem_ext = {rem_q, nm_q[MW-1]};
  assign div_ge  = rem_ext >= {1'b0, cnt_q};

  // Pack and round to nearest even from the normalised value
  assign exf        = nm_q[MW-2] ? ne_q[7:0] : 8'd0;
  assign rnd_up     = nm_q[26] & ((|nm_q[25:0]) | stk_q | nm_q[27]);
  assign packed_rnd = {1'b0, exf, nm_q[49:27]} + {31'd0, rnd_up};

  // Sequence setup, division and normalisation
  always_comb begin
    phase_d = phase_q;
    nm_d    = nm_q;
    ne_d    = ne_q;
    stk_d   = stk_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          stk_d   = 1'b0;
          phase_d = PH_NORM;
          if (special) begin
            res_d   = imse_pkg::FP_POS_INF;
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            case (req_i.op)
              imse_pkg::OP_SUB: begin
                // Unlike signs widen the gap, so take the magnitude sum
                if (req_i.a[31] != req_i.b[31]) begin
                  nm_d  = add_sum;
                  stk_d = al_stk;
                end else begin
                  nm_d  = sub_ext[MW:1];
                  stk_d = sub_ext[0];
                end
                ne_d  = $signed({3'b000, x_op[30:23]});
              end
              imse_pkg::OP_ADD: begin
                nm_d  = add_sum;
                stk_d = al_stk;
                ne_d  = $signed({3'b000, x_op[30:23]});
              end
              imse_pkg::OP_MUL: begin
                nm_d = {prod, 4'd0};
                ne_d = mul_exp;
              end
              imse_pkg::OP_DIV: begin
                nm_d    = {1'b0, a_sig, 27'd0};
                ne_d    = $signed({3'b000, a_exp});
                rem_d   = '0;
                cnt_d   = (req_i.cnt == '0) ? imse_pkg::CNT_W'(1) : req_i.cnt;
                step_d  = '0;
                phase_d = PH_DIV;
              end
              default: begin
                nm_d = '0;
              end
            endcase
          end
        end
      end
      PH_DIV: begin
        rem_d  = div_ge ? imse_pkg::CNT_W'(rem_ext - {1'b0, cnt_q})
                        : imse_pkg::CNT_W'(rem_ext);
        nm_d   = {nm_q[MW-2:0], div_ge};
        step_d = step_q + 6'd1;
        if (step_q == DIV_LAST) begin
          stk_d   = (rem_d != '0);
          phase_d = PH_NORM;
        end
      end
      PH_NORM: begin
        if (nm_q == '0) begin
          res_d   = imse_pkg::FP_POS_ZERO;
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end else if (nm_q[MW-1]) begin
          nm_d  = nm_q >> 1;
          stk_d = stk_q | nm_q[0];
          ne_d  = ne_q + 11'sd1;
        end else if (ne_q < 11'sd1) begin
          // Denormalise towards the smallest exponent
          if (ne_q <= -11'sd15) begin
            nm_d  = nm_q >> 16;
            stk_d = stk_q | (|nm_q[15:0]);
            ne_d  = ne_q + 11'sd16;
          end else begin
            nm_d  = nm_q >> 1;
            stk_d = stk_q | nm_q[0];
            ne_d  = ne_q + 11'sd1;
          end
        end else if (!nm_q[MW-2] && (ne_q > 11'sd1)) begin
          if ((nm_q[MW-2:MW-17] == '0) && (ne_q > 11'sd16)) begin
            nm_d = nm_q << 16;
            ne_d = ne_q - 11'sd16;
          end else begin
            nm_d = nm_q << 1;
            ne_d = ne_q - 11'sd1;
          end
        end else begin
          res_d   = (ne_q >= 11'sd255) ? imse_pkg::FP_POS_INF : packed_rnd;
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    nm_q  <= nm_d;
    ne_q  <= ne_d;
    stk_q <= stk_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire
